// ----- rtl/hrs_pkg.sv -----
`default_nettype none
package hrs_pkg;

  localparam int VALUE_BITS = 32;
  localparam int BYTE_W     = 8;
  localparam int OUT_W      = 32;
  localparam int CONN_W     = 31;
  localparam int KEY_POS_W  = 4;

  localparam logic [CONN_W-1:0]    CONN_RESET  = CONN_W'(1);
  localparam logic [KEY_POS_W-1:0] KEY_POS_MAX = '1;
  localparam logic [KEY_POS_W-1:0] SLEEP_LEN   = KEY_POS_W'(7);
  localparam logic [KEY_POS_W-1:0] REQUEST_LEN = KEY_POS_W'(9);

  localparam logic [BYTE_W-1:0] CR_CHAR    = 8'h0D;
  localparam logic [BYTE_W-1:0] LF_CHAR    = 8'h0A;
  localparam logic [BYTE_W-1:0] TAB_CHAR   = 8'h09;
  localparam logic [BYTE_W-1:0] SP_CHAR    = 8'h20;
  localparam logic [BYTE_W-1:0] COLON_CHAR = 8'h3A;
  localparam logic [BYTE_W-1:0] PLUS_CHAR  = 8'h2B;
  localparam logic [BYTE_W-1:0] MINUS_CHAR = 8'h2D;
  localparam logic [BYTE_W-1:0] ZERO_CHAR  = 8'h30;
  localparam logic [BYTE_W-1:0] NINE_CHAR  = 8'h39;

  typedef enum logic [2:0] {
    PH_BEGIN,
    PH_KEY,
    PH_COLON,
    PH_VALUE,
    PH_CR
  } line_phase_t;

  typedef enum logic [1:0] {
    NP_SKIP,
    NP_SIGN,
    NP_DIGITS,
    NP_DONE
  } num_phase_t;

  typedef logic [1:0] term_progress_t;

  typedef struct packed {
    logic [OUT_W-1:0]  sleep_ms;
    logic [OUT_W-1:0]  request_number;
    logic [OUT_W-1:0]  reply_count;
    logic [CONN_W-1:0] connection_number;
  } result_t;

  function automatic logic [BYTE_W-1:0] sleep_char(input logic [KEY_POS_W-1:0] pos);
    logic [BYTE_W-1:0] ch;
    case (pos)
      4'd0:    ch = "X";
      4'd1:    ch = "-";
      4'd2:    ch = "S";
      4'd3:    ch = "l";
      4'd4:    ch = "e";
      4'd5:    ch = "e";
      4'd6:    ch = "p";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [BYTE_W-1:0] request_char(input logic [KEY_POS_W-1:0] pos);
    logic [BYTE_W-1:0] ch;
    case (pos)
      4'd0:    ch = "X";
      4'd1:    ch = "-";
      4'd2:    ch = "R";
      4'd3:    ch = "e";
      4'd4:    ch = "q";
      4'd5:    ch = "u";
      4'd6:    ch = "e";
      4'd7:    ch = "s";
      4'd8:    ch = "t";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/hrs_in_if.sv -----
`default_nettype none
interface hrs_in_if;
  import hrs_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ----- rtl/hrs_out_if.sv -----
`default_nettype none
interface hrs_out_if;
  import hrs_pkg::*;

  logic              valid;
  logic              ready;
  logic [OUT_W-1:0]  sleep_ms;
  logic [OUT_W-1:0]  request_number;
  logic [OUT_W-1:0]  reply_count;
  logic [CONN_W-1:0] connection_number;

  modport source (
    output valid, output sleep_ms, output request_number, output reply_count,
    output connection_number, input ready
  );
  modport sink (
    input valid, input sleep_ms, input request_number, input reply_count,
    input connection_number, output ready
  );
endinterface
`default_nettype wire

// ----- rtl/http_request_header_scanner.sv -----
`default_nettype none
// Scans an HTTP request byte stream at one byte per clock and emits one result
// per end of message (CR LF CR LF): the last valid X-Sleep and X-Request values
// seen since the previous result (zero if absent), a reply count starting at 1
// and the configured connection id. All per-byte work sits between the byte
// transfer and a single state/result register stage, so a byte is taken every
// cycle; the result is registered on the closing LF, into the result register if free, else the skid.
// A two-entry output buffer (result register plus skid) lets input continue
// while a result waits; input stalls only when both entries are held.
// Write connection_id only while the block is idle.
module http_request_header_scanner (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        cfg_wr_en,
  input  wire [hrs_pkg::CONN_W-1:0]  cfg_wr_data,
  hrs_in_if.sink                     in_ch,
  hrs_out_if.source                  out_ch
);
  import hrs_pkg::*;

  localparam int ACC_W = VALUE_BITS + 4;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

  logic [CONN_W-1:0]     connection_id;
  term_progress_t        term_progress, term_progress_next;
  line_phase_t           line_phase, line_phase_next;
  logic                  line_invalid, line_invalid_next;
  logic [KEY_POS_W-1:0]  key_position, key_position_next;
  logic                  key_may_be_sleep, key_may_be_sleep_next;
  logic                  key_may_be_request, key_may_be_request_next;
  num_phase_t            num_phase, num_phase_next;
  logic                  num_negative, num_negative_next;
  logic [VALUE_BITS-1:0] num_acc, num_acc_next;
  logic                  num_saturated, num_saturated_next;
  logic [VALUE_BITS-1:0] pending_sleep, pending_sleep_next;
  logic [VALUE_BITS-1:0] pending_request, pending_request_next;
  logic [OUT_W-1:0]      reply_counter, reply_counter_next;

  logic                  out_valid;
  result_t               out_data;
  logic                  skid_valid;
  result_t               skid_data;
  result_t               new_result;

  logic                  in_fire;
  logic                  pop;
  logic                  eom;
  logic [BYTE_W-1:0]     ch;
  logic                  is_digit;
  logic [ACC_W-1:0]      acc_times_ten;
  logic                  acc_overflow;
  logic [VALUE_BITS-1:0] num_value;

  assign in_ch.ready = !skid_valid;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign pop         = out_valid && out_ch.ready;
  assign ch          = in_ch.rx_byte;
  assign is_digit    = ch inside {[ZERO_CHAR:NINE_CHAR]};

  assign acc_times_ten = (ACC_W'(num_acc) << 3) + (ACC_W'(num_acc) << 1)
                       + ACC_W'(ch[3:0]);
  assign acc_overflow  = |acc_times_ten[ACC_W-1:VALUE_BITS];

  always_comb begin
    if (num_saturated) begin
      num_value = VALUE_MAX;
    end else if (num_negative) begin
      num_value = VALUE_BITS'(0) - num_acc;
    end else begin
      num_value = num_acc;
    end
  end

  // end of message matcher
  always_comb begin
    eom = 1'b0;
    term_progress_next = term_progress;
    if (in_fire) begin
      if (ch == (term_progress[0] ? LF_CHAR : CR_CHAR)) begin
        if (term_progress == 2'd3) begin
          eom = 1'b1;
          term_progress_next = 2'd0;
        end else begin
          term_progress_next = term_progress + 2'd1;
        end
      end else begin
        term_progress_next = (ch == CR_CHAR) ? 2'd1 : 2'd0;
      end
    end
  end

  // header line tracker
  always_comb begin
    line_phase_next         = line_phase;
    line_invalid_next       = line_invalid;
    key_position_next       = key_position;
    key_may_be_sleep_next   = key_may_be_sleep;
    key_may_be_request_next = key_may_be_request;
    num_phase_next          = num_phase;
    num_negative_next       = num_negative;
    num_acc_next            = num_acc;
    num_saturated_next      = num_saturated;
    pending_sleep_next      = pending_sleep;
    pending_request_next    = pending_request;
    reply_counter_next      = reply_counter;
    if (in_fire) begin
      if (ch == LF_CHAR) begin
        if (line_phase == PH_CR && !line_invalid) begin
          if (key_may_be_sleep && key_position == SLEEP_LEN) begin
            pending_sleep_next = num_value;
          end else if (key_may_be_request && key_position == REQUEST_LEN) begin
            pending_request_next = num_value;
          end
        end
        line_phase_next         = PH_BEGIN;
        line_invalid_next       = 1'b0;
        key_position_next       = '0;
        key_may_be_sleep_next   = 1'b1;
        key_may_be_request_next = 1'b1;
        num_phase_next          = NP_SKIP;
        num_negative_next       = 1'b0;
        num_acc_next            = '0;
        num_saturated_next      = 1'b0;
      end else begin
        case (line_phase)
          PH_COLON: begin
            if (ch == SP_CHAR) begin
              line_phase_next = PH_VALUE;
            end else begin
              line_invalid_next = 1'b1;
            end
          end
          PH_VALUE: begin
            if (ch == CR_CHAR) begin
              line_phase_next = PH_CR;
            end else begin
              case (num_phase)
                NP_SKIP, NP_SIGN, NP_DIGITS: begin
                  if (num_phase == NP_SKIP && ch inside {SP_CHAR, [TAB_CHAR:CR_CHAR]}) begin
                    num_phase_next = NP_SKIP;
                  end else if (num_phase == NP_SKIP
                               && (ch == PLUS_CHAR || ch == MINUS_CHAR)) begin
                    num_negative_next = (ch == MINUS_CHAR);
                    num_phase_next    = NP_SIGN;
                  end else if (is_digit) begin
                    num_phase_next = NP_DIGITS;
                    if (!num_saturated) begin
                      if (acc_overflow) begin
                        num_saturated_next = 1'b1;
                      end else begin
                        num_acc_next = acc_times_ten[VALUE_BITS-1:0];
                      end
                    end
                  end else begin
                    num_phase_next = NP_DONE;
                  end
                end
                default: begin
                  num_phase_next = num_phase;
                end
              endcase
            end
          end
          PH_CR: begin
            line_invalid_next = 1'b1;
          end
          default: begin
            if (line_phase == PH_KEY && ch == COLON_CHAR) begin
              line_phase_next = PH_COLON;
            end else begin
              if (key_position >= SLEEP_LEN || ch != sleep_char(key_position)) begin
                key_may_be_sleep_next = 1'b0;
              end
              if (key_position >= REQUEST_LEN || ch != request_char(key_position)) begin
                key_may_be_request_next = 1'b0;
              end
              if (key_position != KEY_POS_MAX) begin
                key_position_next = key_position + KEY_POS_W'(1);
              end
              line_phase_next = PH_KEY;
            end
          end
        endcase
      end
      if (eom) begin
        reply_counter_next   = reply_counter + OUT_W'(1);
        pending_sleep_next   = '0;
        pending_request_next = '0;
      end
    end
  end

  always_comb begin
    new_result.sleep_ms          = OUT_W'(pending_sleep_next);
    new_result.request_number    = OUT_W'(pending_request_next);
    new_result.reply_count       = reply_counter + OUT_W'(1);
    new_result.connection_number = connection_id;
    if (eom) begin
      new_result.sleep_ms       = OUT_W'(in_fire && line_phase == PH_CR && !line_invalid
                                  && key_may_be_sleep && key_position == SLEEP_LEN
                                  ? num_value : pending_sleep);
      new_result.request_number = OUT_W'(in_fire && line_phase == PH_CR && !line_invalid
                                  && !(key_may_be_sleep && key_position == SLEEP_LEN)
                                  && key_may_be_request && key_position == REQUEST_LEN
                                  ? num_value : pending_request);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      connection_id      <= CONN_RESET;
      term_progress      <= 2'd0;
      line_phase         <= PH_BEGIN;
      line_invalid       <= 1'b0;
      key_position       <= '0;
      key_may_be_sleep   <= 1'b1;
      key_may_be_request <= 1'b1;
      num_phase          <= NP_SKIP;
      num_negative       <= 1'b0;
      num_acc            <= '0;
      num_saturated      <= 1'b0;
      pending_sleep      <= '0;
      pending_request    <= '0;
      reply_counter      <= '0;
    end else begin
      if (cfg_wr_en) begin
        connection_id <= cfg_wr_data;
      end
      term_progress      <= term_progress_next;
      line_phase         <= line_phase_next;
      line_invalid       <= line_invalid_next;
      key_position       <= key_position_next;
      key_may_be_sleep   <= key_may_be_sleep_next;
      key_may_be_request <= key_may_be_request_next;
      num_phase          <= num_phase_next;
      num_negative       <= num_negative_next;
      num_acc            <= num_acc_next;
      num_saturated      <= num_saturated_next;
      pending_sleep      <= pending_sleep_next;
      pending_request    <= pending_request_next;
      reply_counter      <= reply_counter_next;
    end
  end

  // result register with skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= eom;
      end else begin
        out_valid  <= eom;
      end
    end else if (eom) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (eom) begin
          skid_data <= new_result;
        end
      end else begin
        out_data <= new_result;
      end
    end else if (eom) begin
      skid_data <= new_result;
    end
  end

  assign out_ch.valid             = out_valid;
  assign out_ch.sleep_ms          = out_data.sleep_ms;
  assign out_ch.request_number    = out_data.request_number;
  assign out_ch.reply_count       = out_data.reply_count;
  assign out_ch.connection_number = out_data.connection_number;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a result in the output register");

  a_eom_on_lf: assert property (@(posedge clk) disable iff (rst)
    eom |-> (in_fire && in_ch.rx_byte == LF_CHAR))
    else $error("end of message on a byte other than a transferred LF");

  a_pending_cleared: assert property (@(posedge clk) disable iff (rst)
    $past(eom) |-> (pending_sleep == '0 && pending_request == '0))
    else $error("pending values not cleared after end of message");

  a_line_begin_key: assert property (@(posedge clk) disable iff (rst)
    (line_phase == PH_BEGIN) |-> (key_position == '0 && !line_invalid))
    else $error("line begin with key progress or invalid mark left over");

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import hrs_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int SLEEP_CHARS   = 7;
  localparam int REQUEST_CHARS = 9;

  localparam logic [8*SLEEP_CHARS-1:0]   SLEEP_NAME   = "X-Sleep";
  localparam logic [8*REQUEST_CHARS-1:0] REQUEST_NAME = "X-Request";

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [CONN_W-1:0] cfg_wr_data;

  hrs_in_if  in_ch ();
  hrs_out_if out_ch ();

  http_request_header_scanner u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  logic [CONN_W-1:0]     conn_id;
  term_progress_t        term_prog;
  line_phase_t           line_ph;
  logic                  line_bad;
  logic [KEY_POS_W-1:0]  key_pos;
  logic                  maybe_sleep;
  logic                  maybe_request;
  num_phase_t            num_ph;
  logic                  num_neg;
  logic [VALUE_BITS-1:0] num_acc;
  logic                  num_sat;
  logic [OUT_W-1:0]      sleep_pending;
  logic [OUT_W-1:0]      request_pending;
  logic [OUT_W-1:0]      reply_total;

  result_t     pending_replies[$];
  logic [7:0]  request_bytes[$];
  int unsigned errors;
  int unsigned bytes_sent;
  int          idle_cycles;
  bit          src_steady;
  bit          sink_steady;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // header scanner model

  function automatic void clear_line();
    line_ph       = PH_BEGIN;
    line_bad      = 1'b0;
    key_pos       = '0;
    maybe_sleep   = 1'b1;
    maybe_request = 1'b1;
    num_ph        = NP_SKIP;
    num_neg       = 1'b0;
    num_acc       = '0;
    num_sat       = 1'b0;
  endfunction

  function automatic void reset_scanner();
    conn_id         = CONN_RESET;
    term_prog       = '0;
    sleep_pending   = '0;
    request_pending = '0;
    reply_total     = '0;
    clear_line();
  endfunction

  function automatic void match_key(input logic [7:0] c);
    int kp;
    kp = int'(key_pos);
    if (kp < SLEEP_CHARS) begin
      if (c != SLEEP_NAME[8*(SLEEP_CHARS-1-kp) +: 8]) maybe_sleep = 1'b0;
    end else begin
      maybe_sleep = 1'b0;
    end
    if (kp < REQUEST_CHARS) begin
      if (c != REQUEST_NAME[8*(REQUEST_CHARS-1-kp) +: 8]) maybe_request = 1'b0;
    end else begin
      maybe_request = 1'b0;
    end
    if (key_pos != KEY_POS_MAX) key_pos = key_pos + KEY_POS_W'(1);
  endfunction

  function automatic void add_digit(input logic [7:0] c);
    logic [63:0] d;
    logic [63:0] lim;
    d = 64'(c) - 64'(ZERO_CHAR);
    num_ph = NP_DIGITS;
    if (!num_sat) begin
      lim = (64'({VALUE_BITS{1'b1}}) - d) / 64'd10;
      if (64'(num_acc) > lim) num_sat = 1'b1;
      else num_acc = VALUE_BITS'(64'(num_acc) * 64'd10 + d);
    end
  endfunction

  function automatic void feed_number(input logic [7:0] c);
    logic digit;
    logic blank;
    digit = (c >= ZERO_CHAR) && (c <= NINE_CHAR);
    blank = (c == SP_CHAR) || ((c >= TAB_CHAR) && (c <= CR_CHAR));
    case (num_ph)
      NP_SKIP: begin
        if (c == PLUS_CHAR || c == MINUS_CHAR) begin
          num_neg = (c == MINUS_CHAR);
          num_ph  = NP_SIGN;
        end else if (digit) begin
          add_digit(c);
        end else if (!blank) begin
          num_ph = NP_DONE;
        end
      end
      NP_SIGN, NP_DIGITS: begin
        if (digit) add_digit(c);
        else num_ph = NP_DONE;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [OUT_W-1:0] number_value();
    if (num_sat) return '1;
    if (num_neg) return -num_acc;
    return num_acc;
  endfunction

  function automatic void feed_header(input logic [7:0] c);
    case (line_ph)
      PH_KEY: begin
        if (c == COLON_CHAR) line_ph = PH_COLON;
        else match_key(c);
      end
      PH_COLON: begin
        if (c == SP_CHAR) line_ph = PH_VALUE;
        else line_bad = 1'b1;
      end
      PH_VALUE: begin
        if (c == CR_CHAR) line_ph = PH_CR;
        else feed_number(c);
      end
      PH_CR: begin
        if (c == LF_CHAR) begin
          if (!line_bad) begin
            if (maybe_sleep && key_pos == SLEEP_LEN) sleep_pending = number_value();
            else if (maybe_request && key_pos == REQUEST_LEN) request_pending = number_value();
          end
        end else begin
          line_bad = 1'b1;
        end
      end
      default: begin
        match_key(c);
        line_ph = PH_KEY;
      end
    endcase
    if (c == LF_CHAR) clear_line();
  endfunction

  function automatic void scan_byte(input logic [7:0] c);
    logic    eom;
    result_t reply;
    eom = 1'b0;
    // terminator pattern is CR LF CR LF: odd positions want LF
    if (c == (term_prog[0] ? LF_CHAR : CR_CHAR)) begin
      if (term_prog == 2'd3) begin
        term_prog = 2'd0;
        eom = 1'b1;
      end else begin
        term_prog = term_prog + 2'd1;
      end
    end else begin
      term_prog = (c == CR_CHAR) ? 2'd1 : 2'd0;
    end
    feed_header(c);
    if (eom) begin
      clear_line();
      reply_total = reply_total + OUT_W'(1);
      reply.sleep_ms          = sleep_pending;
      reply.request_number    = request_pending;
      reply.reply_count       = reply_total;
      reply.connection_number = conn_id;
      pending_replies = {pending_replies, reply};
      sleep_pending   = '0;
      request_pending = '0;
    end
  endfunction

  // request text

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    request_bytes = {request_bytes, b};
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_crlf();
    add_byte(CR_CHAR);
    add_byte(LF_CHAR);
  endfunction

  function automatic void add_random_value();
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0: add_byte(SP_CHAR);
        1: add_byte(TAB_CHAR);
        2: add_byte(8'h0B);
        default: add_byte(8'h0C);
      endcase
    end
    case ($urandom_range(0, 5))
      0: add_byte(PLUS_CHAR);
      1: add_byte(MINUS_CHAR);
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0: ;
      1: add_text("4294967295");
      2: add_text("4294967296");
      3: repeat ($urandom_range(11, 14)) add_byte(8'(ZERO_CHAR + $urandom_range(0, 9)));
      4: add_text("000");
      default: add_text($sformatf("%0d", $urandom >> $urandom_range(0, 31)));
    endcase
    if ($urandom_range(0, 4) == 0) begin
      add_byte(8'($urandom_range(8'h21, 8'h7E)));
      add_text("7");
    end
  endfunction

  function automatic void add_random_line();
    case ($urandom_range(0, 11))
      0, 1, 2, 3: add_text("X-Sleep");
      4, 5, 6: add_text("X-Request");
      7: begin
        case ($urandom_range(0, 5))
          0: add_text("X-Slee");
          1: add_text("X-Sleeps");
          2: add_text("x-Sleep");
          3: add_text("X-Reques");
          4: add_text("X-Requestt");
          default: add_text("X-Request-Identifier");
        endcase
      end
      8: add_text(":X-Sleep");
      9: repeat ($urandom_range(0, 20)) add_byte(8'($urandom_range(0, 255)));
      10: ;
      default: repeat ($urandom_range(1, 18)) add_byte(8'($urandom_range(8'h21, 8'h7E)));
    endcase
    case ($urandom_range(0, 9))
      0: begin
        add_byte(COLON_CHAR);
        add_byte(8'($urandom_range(8'h21, 8'hFF)));
        add_byte(SP_CHAR);
      end
      1: ;
      default: add_text(": ");
    endcase
    add_random_value();
    case ($urandom_range(0, 11))
      0: begin
        add_byte(CR_CHAR);
        add_byte(8'($urandom_range(0, 255)));
        add_byte(LF_CHAR);
      end
      1: add_byte(LF_CHAR);
      2: begin
        add_byte(CR_CHAR);
        add_crlf();
      end
      default: add_crlf();
    endcase
  endfunction

  function automatic void add_random_message();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 1) == 0) begin
      add_text("GET / HTTP/1.1");
      add_crlf();
    end
    repeat ($urandom_range(0, 4)) add_random_line();
    add_crlf();
  endfunction

  // channel driving

  task automatic send_byte(input logic [7:0] c);
    int gap;
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    scan_byte(c);
    bytes_sent++;
  endtask

  task automatic send_request_bytes();
    logic [7:0] b;
    while (request_bytes.size() != 0) begin
      b = request_bytes[0];
      request_bytes.delete(0);
      send_byte(b);
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_connection(input logic [CONN_W-1:0] id);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= id;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    conn_id = id;
  endtask

  task automatic run_requests(input int unsigned budget);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      src_steady = ($urandom_range(0, 4) == 0);
      add_random_message();
      send_request_bytes();
    end
  endtask

  // tests

  task automatic test_directed_headers();
    src_steady = 1'b0;
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(LF_CHAR);
    add_text("X-Sleep: 99999999999");
    add_crlf();
    add_crlf();
    send_request_bytes();
  endtask

  task automatic test_connection_extremes();
    set_connection('0);
    run_requests(600);
    set_connection('1);
    run_requests(600);
  endtask

  task automatic test_random_requests();
    repeat (2) begin
      set_connection(CONN_W'($urandom));
      run_requests(350);
    end
  endtask

  // output side: stall at random, with steady stretches

  initial begin
    int unsigned hold;
    hold = 0;
    sink_steady = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 299) == 0) sink_steady = !sink_steady;
      if (hold != 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!sink_steady && $urandom_range(0, 2) == 0) hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected result transfer: reply_count %0d", out_ch.reply_count);
        errors++;
      end else begin
        want = pending_replies[0];
        pending_replies.delete(0);
        if (out_ch.sleep_ms !== want.sleep_ms) begin
          $error("sleep_ms: expected %0d, got %0d", want.sleep_ms, out_ch.sleep_ms);
          errors++;
        end
        if (out_ch.request_number !== want.request_number) begin
          $error("request_number: expected %0d, got %0d",
                 want.request_number, out_ch.request_number);
          errors++;
        end
        if (out_ch.reply_count !== want.reply_count) begin
          $error("reply_count: expected %0d, got %0d", want.reply_count, out_ch.reply_count);
          errors++;
        end
        if (out_ch.connection_number !== want.connection_number) begin
          $error("connection_number: expected %0d, got %0d",
                 want.connection_number, out_ch.connection_number);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst           <= 1'b1;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    errors     = 0;
    bytes_sent = 0;
    src_steady = 1'b0;
    reset_scanner();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed_headers();
    test_connection_extremes();
    test_random_requests();

    wait_idle();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
